FILE: hdl/dllw_pkg.sv
`default_nettype none
package dllw_pkg;

  localparam logic [23:0] TERMINATOR       = 24'hFFFFFF;
  localparam logic [23:0] ADDR_MASK        = 24'h1FFFFC;
  localparam logic [23:0] STEP_LIMIT_RESET = 24'd2000000;
  localparam logic [31:0] SIZE_MAX         = 32'hFFFFFFFF;

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 88;

  typedef enum logic [1:0] {
    CAUSE_TERM  = 2'd0,
    CAUSE_LOOP  = 2'd1,
    CAUSE_LIMIT = 2'd2
  } cause_t;

  // Walk state carried between items.
  typedef struct packed {
    logic        walking;
    logic [20:0] current_node;
    logic [23:0] last_visited;
    logic [23:0] low_mark;
    logic [23:0] high_mark;
    logic [23:0] nodes_visited;
    logic [31:0] size_sum;
  } walk_state_t;

  typedef struct packed {
    logic [20:0] fetch_addr;
    logic        fetch_valid;
    logic [21:0] payload_addr;
    logic [7:0]  payload_count;
    logic        done_res;
    cause_t      end_cause;
    logic [31:0] total_words;
  } result_t;

  localparam walk_state_t STATE_RESET = '{
    walking:       1'b0,
    current_node:  21'd0,
    last_visited:  TERMINATOR,
    low_mark:      TERMINATOR,
    high_mark:     TERMINATOR,
    nodes_visited: 24'd0,
    size_sum:      32'd0
  };

endpackage
`default_nettype wire

FILE: hdl/dllw_node_logic.sv
`default_nettype none
// One item of the walk: state in, next state and result out.
module dllw_node_logic (
  input  wire logic                 kind,
  input  wire logic [23:0]          start_addr,
  input  wire logic [31:0]          header_word,
  input  wire logic [23:0]          step_limit,
  input  wire dllw_pkg::walk_state_t st,
  output dllw_pkg::walk_state_t     st_next,
  output dllw_pkg::result_t         res
);

  dllw_pkg::walk_state_t base;
  logic [7:0]  cnt;
  logic [32:0] sum_wide;
  logic [31:0] sum_sat;
  logic [23:0] next_raw;
  logic [23:0] next_masked;
  logic        loop_hit;
  logic        limit_hit;

  always_comb begin
    cnt         = header_word[31:24];
    sum_wide    = {1'b0, st.size_sum} + {25'd0, cnt} + 33'd1;
    sum_sat     = sum_wide[32] ? dllw_pkg::SIZE_MAX : sum_wide[31:0];
    next_raw    = kind ? header_word[23:0] : start_addr;
    next_masked = next_raw & dllw_pkg::ADDR_MASK;

    // A start clears the marks and the visit count and sets the size sum to one before the head node is visited.
    base = st;
    if (!kind) begin
      base.last_visited  = dllw_pkg::TERMINATOR;
      base.low_mark      = dllw_pkg::TERMINATOR;
      base.high_mark     = dllw_pkg::TERMINATOR;
      base.nodes_visited = 24'd0;
      base.size_sum      = 32'd1;
    end else begin
      base.size_sum      = sum_sat;
    end

    limit_hit = base.nodes_visited > step_limit;
    loop_hit  = (next_masked == base.low_mark) || (next_masked == base.high_mark);
  end

  always_comb begin
    st_next = st;
    res     = '0;
    if (kind && !st.walking) begin
      // header with no walk in progress: dropped
    end else if (kind && next_raw == dllw_pkg::TERMINATOR) begin
      st_next          = st;
      st_next.size_sum = sum_sat;
      st_next.walking  = 1'b0;
      res.payload_addr  = {1'b0, st.current_node} + 22'd4;
      res.payload_count = cnt;
      res.done_res      = 1'b1;
      res.end_cause     = dllw_pkg::CAUSE_TERM;
      res.total_words   = sum_sat;
    end else begin
      st_next = base;
      if (base.nodes_visited != dllw_pkg::TERMINATOR) begin
        st_next.nodes_visited = base.nodes_visited + 24'd1;
      end
      if (kind) begin
        res.payload_addr  = {1'b0, st.current_node} + 22'd4;
        res.payload_count = cnt;
      end
      res.total_words = base.size_sum;
      if (limit_hit) begin
        st_next.walking = 1'b0;
        res.done_res    = 1'b1;
        res.end_cause   = dllw_pkg::CAUSE_LIMIT;
      end else if (loop_hit) begin
        st_next.walking = 1'b0;
        res.done_res    = 1'b1;
        res.end_cause   = dllw_pkg::CAUSE_LOOP;
      end else begin
        if (next_masked < base.last_visited) begin
          st_next.low_mark = next_masked;
        end else begin
          st_next.high_mark = next_masked;
        end
        st_next.last_visited = next_masked;
        st_next.current_node = next_masked[20:0];
        st_next.walking      = 1'b1;
        res.fetch_addr       = next_masked[20:0];
        res.fetch_valid      = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dma_linked_list_walker.sv
// A request is captured in the input register when accepted; its result is then
// registered into the output register, which drives m_*.
// Throughput: one request per cycle while results are taken; the node logic sits
// between the input and result registers. A held result stalls s_tready.
// Reset (rst, synchronous, active high): no walk in progress, marks at
// 0xFFFFFF, counters zero, step_limit back to 2000000, both stages empty.
`default_nettype none
module dma_linked_list_walker (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: step_limit
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  // requests in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // start_addr[23:0], header_word[55:24]
  input  wire logic [dllw_pkg::S_TDATA_W-1:0] s_tdata,
  input  wire logic        s_tuser,   // kind
  // results out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // fetch_addr[20:0], payload_addr[42:21], payload_count[50:43],
  // end_cause[52:51], total_words[84:53], zero[87:85]
  output logic [dllw_pkg::M_TDATA_W-1:0] m_tdata,
  output logic             m_tuser,   // fetch_valid
  output logic             m_tlast    // done_res
);

  logic [23:0] step_limit;

  // input register
  logic        stage_valid;
  logic        stage_kind;
  logic [dllw_pkg::S_TDATA_W-1:0] stage_data;

  dllw_pkg::walk_state_t st;
  dllw_pkg::walk_state_t st_next;
  dllw_pkg::result_t     res;
  dllw_pkg::result_t     res_q;

  logic out_free;
  logic advance;

  // The output register frees when empty or taken this cycle; the stage
  // moves into it then, and the input register refills in the same edge.
  assign out_free = !m_tvalid || m_tready;
  assign advance  = stage_valid && out_free;
  assign s_tready = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= dllw_pkg::STEP_LIMIT_RESET;
    end else if (cfg_we) begin
      step_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_kind <= s_tuser;
      stage_data <= s_tdata;
    end
  end

  dllw_node_logic u_node (
    .kind        (stage_kind),
    .start_addr  (stage_data[23:0]),
    .header_word (stage_data[55:24]),
    .step_limit  (step_limit),
    .st          (st),
    .st_next     (st_next),
    .res         (res)
  );

  // walk state commits only when the staged request hands off its result
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= dllw_pkg::STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = {3'b000, res_q.total_words, logic'(res_q.end_cause[1]),
                    logic'(res_q.end_cause[0]), res_q.payload_count,
                    res_q.payload_addr, res_q.fetch_addr};
  assign m_tuser = res_q.fetch_valid;
  assign m_tlast = res_q.done_res;

endmodule
`default_nettype wire
